// ===== src/jase_pkg.sv =====
// shared types and constants for the jpeg app segment extractor
`timescale 1ns / 1ps

package jase_pkg;

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] SOI_CODE    = 8'hD8;
    localparam logic [7:0] SOS_CODE    = 8'hDA;
    localparam logic [7:0] EOI_CODE    = 8'hD9;
    localparam logic [7:0] APP_FIRST   = 8'hE0;
    localparam logic [7:0] APP_LAST    = 8'hEF;
    localparam logic [15:0] LEN_MIN    = 16'd2;

    localparam logic [1:0] SIG_IDX_LAST = 2'd2;
    localparam logic [1:0] SIG_IDX_SOI  = 2'd1;

    // result kinds
    localparam logic [2:0] K_PAYLOAD = 3'd0;
    localparam logic [2:0] K_EMPTY   = 3'd1;
    localparam logic [2:0] K_STOP    = 3'd2;
    localparam logic [2:0] K_END     = 3'd3;
    localparam logic [2:0] K_BADSIG  = 3'd4;
    localparam logic [2:0] K_BADLEN  = 3'd5;
    localparam logic [2:0] K_TRUNC   = 3'd6;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_MARK,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  sig_idx;
        logic        prefix_seen;
        logic [7:0]  len_high;
        logic [15:0] remaining;
        logic [3:0]  app;
        logic        is_app;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data;
        logic [3:0] app;
        logic       last;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:       PH_SIG,
        sig_idx:     2'd0,
        prefix_seen: 1'b0,
        len_high:    8'd0,
        remaining:   16'd0,
        app:         4'd0,
        is_app:      1'b0
    };

endpackage

// ===== src/jase_step.sv =====
// per-byte parser step: next state and optional result from current state and one request
`timescale 1ns / 1ps

module jase_step
    import jase_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_data,
    output t_state     o_state,
    output t_result    o_result
);

    logic [15:0] w_len;
    logic [15:0] w_len_net;
    logic        w_is_app_code;
    logic [7:0]  w_sig_byte;

    assign w_len         = {i_state.len_high, i_data_byte};
    assign w_len_net     = w_len - LEN_MIN;
    assign w_is_app_code = (i_data_byte >= APP_FIRST) && (i_data_byte <= APP_LAST);
    assign w_sig_byte    = (i_state.sig_idx == SIG_IDX_SOI) ? SOI_CODE : MARK_PREFIX;

    // next state
    always_comb begin
        o_state = i_state;
        if (i_end_of_data) begin
            o_state = STATE_RESET;
        end else begin
            case (i_state.phase)
                PH_SIG: begin
                    if (i_data_byte != w_sig_byte) begin
                        o_state.phase = PH_DONE;
                    end else if (i_state.sig_idx >= SIG_IDX_LAST) begin
                        o_state.sig_idx     = 2'd0;
                        o_state.prefix_seen = 1'b1;
                        o_state.phase       = PH_MARK;
                    end else begin
                        o_state.sig_idx = i_state.sig_idx + 2'd1;
                    end
                end
                PH_MARK: begin
                    if (!i_state.prefix_seen) begin
                        if (i_data_byte == MARK_PREFIX) begin
                            o_state.prefix_seen = 1'b1;
                        end
                    end else if (i_data_byte != MARK_PREFIX) begin
                        o_state.prefix_seen = 1'b0;
                        if (i_data_byte == SOS_CODE || i_data_byte == EOI_CODE) begin
                            o_state.phase = PH_DONE;
                        end else begin
                            o_state.is_app = w_is_app_code;
                            o_state.app    = w_is_app_code ? i_data_byte[3:0] : 4'd0;
                            o_state.phase  = PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_HI: begin
                    o_state.len_high = i_data_byte;
                    o_state.phase    = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (w_len < LEN_MIN) begin
                        o_state.phase = PH_DONE;
                    end else begin
                        o_state.remaining = w_len_net;
                        if (w_len_net == 16'd0) begin
                            o_state.phase = PH_MARK;
                        end else begin
                            o_state.phase = i_state.is_app ? PH_PAYLOAD : PH_SKIP;
                        end
                    end
                end
                PH_PAYLOAD, PH_SKIP: begin
                    if (i_state.remaining <= 16'd1) begin
                        o_state.remaining = 16'd0;
                        o_state.phase     = PH_MARK;
                    end else begin
                        o_state.remaining = i_state.remaining - 16'd1;
                    end
                end
                default: begin
                    o_state = i_state;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_result = '0;
        if (i_end_of_data) begin
            case (i_state.phase)
                PH_SIG: begin
                    o_result.valid = 1'b1;
                    o_result.kind  = K_BADSIG;
                end
                PH_MARK, PH_SKIP: begin
                    o_result.valid = 1'b1;
                    o_result.kind  = K_END;
                end
                PH_LEN_HI, PH_LEN_LO: begin
                    o_result.valid = 1'b1;
                    if (i_state.is_app) begin
                        o_result.kind = K_TRUNC;
                        o_result.app  = i_state.app;
                    end else begin
                        o_result.kind = K_BADLEN;
                    end
                end
                PH_PAYLOAD: begin
                    o_result.valid = 1'b1;
                    o_result.kind  = K_TRUNC;
                    o_result.app   = i_state.app;
                end
                default: begin
                    o_result = '0;
                end
            endcase
        end else begin
            case (i_state.phase)
                PH_SIG: begin
                    if (i_data_byte != w_sig_byte) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = K_BADSIG;
                    end
                end
                PH_MARK: begin
                    if (i_state.prefix_seen &&
                        (i_data_byte == SOS_CODE || i_data_byte == EOI_CODE)) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = K_STOP;
                    end
                end
                PH_LEN_LO: begin
                    if (w_len < LEN_MIN) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = K_BADLEN;
                    end else if (w_len_net == 16'd0 && i_state.is_app) begin
                        o_result.valid = 1'b1;
                        o_result.kind  = K_EMPTY;
                        o_result.app   = i_state.app;
                    end
                end
                PH_PAYLOAD: begin
                    o_result.valid = 1'b1;
                    o_result.kind  = K_PAYLOAD;
                    o_result.data  = i_data_byte;
                    o_result.app   = i_state.app;
                    o_result.last  = (i_state.remaining <= 16'd1);
                end
                default: begin
                    o_result = '0;
                end
            endcase
        end
    end

endmodule

// ===== src/jpeg_app_segment_extractor.sv =====
// top level of the jpeg app segment extractor: input register, parser step, result register
`timescale 1ns / 1ps

// usage
// - input channel (i_in_valid / o_in_ready) carries one file byte per request, or an
//   end-of-data request (i_end_of_data high) that reports the final status, unless
//   one was already given, and re-arms the parser for the next file
// - output channel (o_out_valid / i_out_ready) carries at most one result per request:
//   an app payload byte with its app number and last flag, an empty-app notice, a
//   stop at sos/eoi, or a terminal status
// - a request lands in the input register, the parser step runs on it there and its
//   result, if any, lands in the output register, which drives o_out_valid
// - throughput is one request per cycle unless a result waits on a stalled output;
//   a body byte's only work is the phase update and the 16-bit remaining-length decrement
// - a request that gives no result moves through even while the output is stalled;
//   one that gives a result waits in the input register until the output register
//   is free or is being drained in the same cycle
// - synchronous active-low reset empties both registers and puts the parser back to
//   expecting the first signature byte

module jpeg_app_segment_extractor
    import jase_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_out_kind,
    output logic [7:0] o_payload_byte,
    output logic [3:0] o_app_number,
    output logic       o_segment_last
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // parser state
    t_state  r_state;
    t_state  n_state;
    t_result w_result;

    // output register
    logic       r_out_valid;
    logic [2:0] r_out_kind;
    logic [7:0] r_out_byte;
    logic [3:0] r_out_app;
    logic       r_out_last;

    logic w_out_free;
    logic w_step;

    jase_step u_step (
        .i_state       (r_state),
        .i_data_byte   (r_in_byte),
        .i_end_of_data (r_in_end),
        .o_state       (n_state),
        .o_result      (w_result)
    );

    // output slot is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    // the held request is processed unless its result has nowhere to go
    assign w_step     = r_in_valid && (!w_result.valid || w_out_free);
    assign o_in_ready = !r_in_valid || w_step;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_end_of_data;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_step) begin
            r_state <= n_state;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_step && w_result.valid) begin
            r_out_kind <= w_result.kind;
            r_out_byte <= w_result.data;
            r_out_app  <= w_result.app;
            r_out_last <= w_result.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out_kind;
    assign o_payload_byte = r_out_byte;
    assign o_app_number   = r_out_app;
    assign o_segment_last = r_out_last;

`ifndef SYNTH
    // a payload or skip body always has bytes left to count
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_PAYLOAD || r_state.phase == PH_SKIP)
            |-> (r_state.remaining != 16'd0))
        else $error("body phase with zero bytes remaining");

    // no marker prefix is recorded while the signature is still being checked
    a_sig_no_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_SIG) |-> !r_state.prefix_seen)
        else $error("prefix flag set during signature check");

    // last payload byte sends the parser back to marker hunting
    a_last_to_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_result.valid && w_result.kind == K_PAYLOAD && w_result.last)
            |=> (r_state.phase == PH_MARK))
        else $error("parser not hunting markers after last payload byte");

    // a result is never written over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_result.valid) |-> w_out_free)
        else $error("result register overwritten while stalled");
`endif

endmodule
